// ----- hw/rtl/tar_archive_entry_walker_macros.svh -----
// Assertion macros for the tar archive entry walker.
// Included by modules that carry concurrent checks; needs no other file.
`ifndef TAR_ARCHIVE_ENTRY_WALKER_MACROS_SVH
`define TAR_ARCHIVE_ENTRY_WALKER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define TAEW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("taew check failed");
// next-cycle implication
`define TAEW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("taew check failed");
`else
`define TAEW_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define TAEW_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- hw/rtl/taew_pkg.sv -----
// Shared types and constants for the tar archive entry walker.
// No dependencies; used by the top level and by the channel payloads.
package taew_pkg;

    localparam int MAX_ENTRIES_DEFAULT = 128;

    localparam logic [31:0] HDR_LEN     = 32'd512;
    localparam logic [31:0] HDR_MASK    = 32'd511;
    localparam logic [7:0]  SIZE_FIRST  = 8'd124;
    localparam logic [7:0]  SIZE_LAST   = 8'd134;
    localparam logic [31:0] SKIP_ADJUST = 32'd377;   // 512 - (SIZE_LAST + 1)
    localparam logic [7:0]  PRINT_LO    = 8'd32;
    localparam logic [7:0]  PRINT_HI    = 8'd126;
    localparam logic [31:0] DIGIT_ZERO  = 32'd48;

    typedef enum logic [1:0] {
        KIND_FILE    = 2'd0,
        KIND_END     = 2'd1,
        KIND_GARBAGE = 2'd2,
        KIND_FULL    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_SKIP   = 3'b010,
        PH_STOP   = 3'b100
    } phase_t;

    typedef struct packed {
        logic [7:0] archive_byte;
        logic       image_start;
    } byte_word_t;

    typedef struct packed {
        kind_t       record_kind;
        logic [6:0]  entry_index;
        logic [31:0] header_address;
        logic [31:0] data_address;
        logic [31:0] file_size;
    } record_word_t;

    typedef logic [31:0] cfg_word_t;

endpackage

// ----- hw/rtl/taew_chan_if.sv -----
// Valid/ready channel carrying one word of a given payload type.
// No dependencies; payload types come from taew_pkg at instantiation.
interface taew_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/tar_archive_entry_walker.sv -----
// Tar archive entry walker: byte stream in, one entry or stop record out.
// The byte that completes a record is taken into the input register; the record is
// then held in the result register. Throughput: one byte per cycle, set by the
// state update; stalls only when the result register is held.
// Reset (rst_n low, asynchronous): walk live at offset 0, base address 0, no entries.
// Depends on taew_pkg, taew_chan_if and tar_archive_entry_walker_macros.svh.
`include "tar_archive_entry_walker_macros.svh"

module tar_archive_entry_walker
    import taew_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEFAULT
)
(
    input  logic         clk,
    input  logic         rst_n,
    taew_chan_if.sink    cfg,
    taew_chan_if.sink    bytes,
    taew_chan_if.source  records
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);

    logic [31:0]  base_reg;
    logic         s1_valid_reg;
    byte_word_t   s1_data_reg;
    logic         out_valid_reg;
    record_word_t out_reg;

    phase_t       phase_reg,  phase_next;
    logic [7:0]   hpos_reg,   hpos_next;
    logic [31:0]  skip_reg,   skip_next;
    logic [31:0]  acc_reg,    acc_next;
    logic [31:0]  off_reg,    off_next;
    logic [31:0]  hdr_reg,    hdr_next;
    logic [CW-1:0] count_reg, count_next;

    logic         s1_adv;
    logic         res_valid;
    record_word_t res;

    logic [7:0]   b;
    logic [31:0]  off;
    phase_t       ph;
    logic [7:0]   hp;
    logic [31:0]  sk;
    logic [31:0]  ac;
    logic [CW-1:0] cnt;
    logic [31:0]  fold;
    logic [31:0]  rnd;
    logic [31:0]  sk_dec;
    logic [31:0]  hdr_addr;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else if (cfg.valid)
        begin
            base_reg <= cfg.payload;
        end
    end

    // input stage
    assign s1_adv      = s1_valid_reg && (!res_valid || !out_valid_reg || records.ready);
    assign bytes.ready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (bytes.ready)
        begin
            s1_valid_reg <= bytes.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bytes.ready && bytes.valid)
        begin
            s1_data_reg <= bytes.payload;
        end
    end

    // walk step
    always_comb
    begin
        b   = s1_data_reg.archive_byte;
        off = s1_data_reg.image_start ? '0 : off_reg;
        ph  = s1_data_reg.image_start ? PH_HEADER : phase_reg;
        hp  = s1_data_reg.image_start ? '0 : hpos_reg;
        sk  = s1_data_reg.image_start ? '0 : skip_reg;
        ac  = s1_data_reg.image_start ? '0 : acc_reg;
        cnt = s1_data_reg.image_start ? '0 : count_reg;

        fold   = {ac[28:0], 3'b000} + ({24'd0, b} - DIGIT_ZERO);
        rnd    = (fold + HDR_MASK) & ~HDR_MASK;
        sk_dec = sk - 32'd1;

        phase_next = ph;
        hpos_next  = hp;
        skip_next  = sk;
        acc_next   = ac;
        count_next = cnt;
        off_next   = off + 32'd1;
        hdr_next   = hdr_reg;

        res_valid       = 1'b0;
        res.record_kind = KIND_FILE;
        res.entry_index = '0;
        res.file_size   = '0;

        case (ph)
            PH_HEADER:
            begin
                if (hp == 8'd0)
                begin
                    hdr_next = off;
                    if (b == 8'd0)
                    begin
                        res_valid       = 1'b1;
                        res.record_kind = KIND_END;
                        phase_next      = PH_STOP;
                    end
                    else if (b < PRINT_LO || b > PRINT_HI)
                    begin
                        res_valid       = 1'b1;
                        res.record_kind = KIND_GARBAGE;
                        phase_next      = PH_STOP;
                    end
                    else if (cnt >= CW'(MAX_ENTRIES))
                    begin
                        res_valid       = 1'b1;
                        res.record_kind = KIND_FULL;
                        phase_next      = PH_STOP;
                    end
                    else
                    begin
                        acc_next  = '0;
                        hpos_next = 8'd1;
                    end
                end
                else
                begin
                    if (hp >= SIZE_FIRST && hp <= SIZE_LAST)
                    begin
                        acc_next = fold;
                    end
                    if (hp == SIZE_LAST)
                    begin
                        res_valid       = 1'b1;
                        res.record_kind = KIND_FILE;
                        res.entry_index = 7'(cnt);
                        res.file_size   = fold;
                        count_next      = cnt + CW'(1);
                        // header remainder plus data rounded to whole blocks
                        skip_next       = rnd + SKIP_ADJUST;
                        hpos_next       = '0;
                        phase_next      = PH_SKIP;
                    end
                    else
                    begin
                        hpos_next = hp + 8'd1;
                    end
                end
            end
            PH_SKIP:
            begin
                skip_next = sk_dec;
                if (sk_dec == 32'd0)
                begin
                    phase_next = PH_HEADER;
                    hpos_next  = '0;
                end
            end
            default:
            begin
                phase_next = PH_STOP;
            end
        endcase

        hdr_addr           = base_reg + hdr_next;
        res.header_address = hdr_addr;
        res.data_address   = hdr_addr + HDR_LEN;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            hpos_reg  <= '0;
            skip_reg  <= '0;
            acc_reg   <= '0;
            off_reg   <= '0;
            hdr_reg   <= '0;
            count_reg <= '0;
        end
        else if (s1_adv)
        begin
            phase_reg <= phase_next;
            hpos_reg  <= hpos_next;
            skip_reg  <= skip_next;
            acc_reg   <= acc_next;
            off_reg   <= off_next;
            hdr_reg   <= hdr_next;
            count_reg <= count_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv && res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (records.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign records.valid   = out_valid_reg;
    assign records.payload = out_reg;

    `TAEW_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(MAX_ENTRIES))
    `TAEW_ASSERT_NOW(a_hpos_in_header, clk, rst_n, hpos_reg != 8'd0, phase_reg == PH_HEADER)
    `TAEW_ASSERT_NEXT(a_stop_after_stop_record, clk, rst_n,
        s1_adv && res_valid && res.record_kind != KIND_FILE, phase_reg == PH_STOP)
    `TAEW_ASSERT_NOW(a_stop_record_empty, clk, rst_n,
        out_valid_reg && out_reg.record_kind != KIND_FILE,
        out_reg.file_size == 32'd0 && out_reg.entry_index == 7'd0)

endmodule
